FILE: src/assert_macros.svh
// Assertion macros shared by the line-program interpreter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DLPI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DLPI_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dlpi_pkg.sv
// Types and constants of the line-number program interpreter.
// Used by the channel interfaces, the divider and the top level.
package dlpi_pkg;

   localparam logic [7:0] OP_EXTENDED         = 8'd0;
   localparam logic [7:0] OP_COPY             = 8'd1;
   localparam logic [7:0] OP_ADVANCE_PC       = 8'd2;
   localparam logic [7:0] OP_ADVANCE_LINE     = 8'd3;
   localparam logic [7:0] OP_SET_FILE         = 8'd4;
   localparam logic [7:0] OP_SET_COLUMN       = 8'd5;
   localparam logic [7:0] OP_NEGATE_STMT      = 8'd6;
   localparam logic [7:0] OP_SET_BASIC_BLOCK  = 8'd7;
   localparam logic [7:0] OP_CONST_ADD_PC     = 8'd8;
   localparam logic [7:0] OP_FIXED_ADVANCE_PC = 8'd9;
   localparam logic [7:0] OP_SET_PROLOGUE_END = 8'd10;
   localparam logic [7:0] OP_SET_EPILOGUE_BEG = 8'd11;
   localparam logic [7:0] OP_SET_ISA          = 8'd12;

   localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
   localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;

   localparam logic [7:0] CONST_ADD_TOP = 8'd255;

   localparam logic [2:0] REG_ADDR_UNIT       = 3'd0;
   localparam logic [2:0] REG_DEFAULT_IS_STMT = 3'd1;
   localparam logic [2:0] REG_LINE_FLOOR      = 3'd2;
   localparam logic [2:0] REG_LINE_SPAN       = 3'd3;
   localparam logic [2:0] REG_FIRST_SPECIAL   = 3'd4;

   typedef struct packed {
      logic [7:0]         opcode;
      logic [7:0]         extended_opcode;
      logic [63:0]        operand;
      logic signed [31:0] line_delta;
   } dlpi_req_type;

   typedef struct packed {
      logic [63:0] row_address;
      logic [31:0] row_line;
      logic [15:0] row_file;
      logic [15:0] row_column;
      logic [7:0]  row_isa;
      logic        row_is_stmt;
      logic        row_basic_block;
      logic        row_end_sequence;
      logic        row_prologue_end;
      logic        row_epilogue_begin;
      logic [63:0] lowest_address;
      logic [63:0] highest_address;
   } dlpi_rsp_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quotient;
      logic [7:0] remainder;
   } dlpi_div_result_type;

endpackage

FILE: src/dlpi_req_if.sv
// Instruction channel: valid, ready and one decoded instruction per beat.
// Depends on dlpi_pkg for the payload type.
interface dlpi_req_if import dlpi_pkg::*; ();
   logic         valid;
   logic         ready;
   dlpi_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/dlpi_rsp_if.sv
// Row channel: valid, ready and one emitted row per beat.
// Depends on dlpi_pkg for the payload type.
interface dlpi_rsp_if import dlpi_pkg::*; ();
   logic         valid;
   logic         ready;
   dlpi_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/dwarf_line_program_interpreter_core.sv
// Line-number program interpreter: one decoded instruction per accepted beat.
// An instruction without a row returns to idle from execute; copy and end_sequence go to emit.
// advance_pc goes through the shift-add loop over the address unit;
// fixed_advance_pc uses it with multiplier 1. const_add_pc and special divide first, then multiply.
// A row is registered in the emit state after the last update; later while the previous row is held.
// Synchronous active-high reset loads register defaults and the initial row state.
`include "assert_macros.svh"
module dwarf_line_program_interpreter_core import dlpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dlpi_req_if.sink    req_if,
   dlpi_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]   state_ff, state_in;
   dlpi_req_type item_ff, item_in;
   logic         emit_ff, emit_in;
   logic         endseq_ff, endseq_in;

   logic [7:0]   mil_ff, mil_in;
   logic         dflt_stmt_ff, dflt_stmt_in;
   logic [7:0]   line_floor_ff, line_floor_in;
   logic [7:0]   line_span_ff, line_span_in;
   logic [7:0]   first_special_ff, first_special_in;

   logic [63:0]  cur_address_ff, cur_address_in;
   logic [31:0]  cur_line_ff, cur_line_in;
   logic [15:0]  cur_file_ff, cur_file_in;
   logic [15:0]  cur_column_ff, cur_column_in;
   logic [7:0]   cur_isa_ff, cur_isa_in;
   logic         cur_is_stmt_ff, cur_is_stmt_in;
   logic         cur_basic_block_ff, cur_basic_block_in;
   logic         cur_prologue_end_ff, cur_prologue_end_in;
   logic         cur_epilogue_begin_ff, cur_epilogue_begin_in;
   logic [63:0]  min_seen_ff, min_seen_in;
   logic [63:0]  max_seen_ff, max_seen_in;

   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  mcand_ff, mcand_in;
   logic [7:0]   mplier_ff, mplier_in;
   logic [63:0]  acc_sum;

   logic         rsp_valid_ff, rsp_valid_in;
   dlpi_rsp_type rsp_payload_ff, rsp_payload_in;

   logic                div_start;
   logic [7:0]          div_dividend;
   dlpi_div_result_type div_res;

   logic         cfg_write;
   logic         req_fire;
   logic         fire_emit;
   logic [63:0]  new_min;
   logic [63:0]  new_max;
   logic [31:0]  special_step;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign req_fire  = req_if.valid && req_if.ready;
   assign fire_emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   assign acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : 64'd0);
   assign new_min = (cur_address_ff < min_seen_ff) ? cur_address_ff : min_seen_ff;
   assign new_max = (cur_address_ff > max_seen_ff) ? cur_address_ff : max_seen_ff;
   assign special_step = {{24{line_floor_ff[7]}}, line_floor_ff} + {24'd0, div_res.remainder};

   dlpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (line_span_ff),
      .result   (div_res)
   );

   always_comb begin
      case (paddr[4:2])
         REG_ADDR_UNIT:       prdata = {24'd0, mil_ff};
         REG_DEFAULT_IS_STMT: prdata = {31'd0, dflt_stmt_ff};
         REG_LINE_FLOOR:      prdata = {24'd0, line_floor_ff};
         REG_LINE_SPAN:       prdata = {24'd0, line_span_ff};
         REG_FIRST_SPECIAL:   prdata = {24'd0, first_special_ff};
         default:             prdata = 32'd0;
      endcase
   end

   always_comb begin
      mil_in           = mil_ff;
      dflt_stmt_in     = dflt_stmt_ff;
      line_floor_in    = line_floor_ff;
      line_span_in     = line_span_ff;
      first_special_in = first_special_ff;
      if (cfg_write) begin
         case (paddr[4:2])
            REG_ADDR_UNIT:       mil_in           = pwdata[7:0];
            REG_DEFAULT_IS_STMT: dflt_stmt_in     = pwdata[0];
            REG_LINE_FLOOR:      line_floor_in    = pwdata[7:0];
            REG_LINE_SPAN:       line_span_in     = pwdata[7:0];
            REG_FIRST_SPECIAL:   first_special_in = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in              = state_ff;
      item_in               = item_ff;
      emit_in               = emit_ff;
      endseq_in             = endseq_ff;
      cur_address_in        = cur_address_ff;
      cur_line_in           = cur_line_ff;
      cur_file_in           = cur_file_ff;
      cur_column_in         = cur_column_ff;
      cur_isa_in            = cur_isa_ff;
      cur_is_stmt_in        = cur_is_stmt_ff;
      cur_basic_block_in    = cur_basic_block_ff;
      cur_prologue_end_in   = cur_prologue_end_ff;
      cur_epilogue_begin_in = cur_epilogue_begin_ff;
      min_seen_in           = min_seen_ff;
      max_seen_in           = max_seen_ff;
      acc_in                = acc_ff;
      mcand_in              = mcand_ff;
      mplier_in             = mplier_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_if.ready;
      rsp_payload_in        = rsp_payload_ff;
      div_start             = 1'b0;
      div_dividend          = item_ff.opcode - first_special_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in  = req_if.payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            emit_in   = 1'b0;
            endseq_in = 1'b0;
            state_in  = ST_IDLE;
            if (item_ff.opcode == OP_EXTENDED) begin
               if (item_ff.extended_opcode == EXT_END_SEQUENCE) begin
                  emit_in   = 1'b1;
                  endseq_in = 1'b1;
                  state_in  = ST_EMIT;
               end else if (item_ff.extended_opcode == EXT_SET_ADDRESS) begin
                  cur_address_in = item_ff.operand;
               end
            end else if (item_ff.opcode < first_special_ff) begin
               case (item_ff.opcode)
                  OP_COPY: begin
                     emit_in  = 1'b1;
                     state_in = ST_EMIT;
                  end
                  OP_ADVANCE_PC: begin
                     acc_in    = cur_address_ff;
                     mcand_in  = item_ff.operand;
                     mplier_in = mil_ff;
                     state_in  = ST_MUL;
                  end
                  OP_ADVANCE_LINE: cur_line_in = cur_line_ff + $unsigned(item_ff.line_delta);
                  OP_SET_FILE:     cur_file_in = item_ff.operand[15:0];
                  OP_SET_COLUMN:   cur_column_in = item_ff.operand[15:0];
                  OP_NEGATE_STMT:  cur_is_stmt_in = !cur_is_stmt_ff;
                  OP_SET_BASIC_BLOCK: cur_basic_block_in = 1'b1;
                  OP_CONST_ADD_PC: begin
                     div_start    = 1'b1;
                     div_dividend = CONST_ADD_TOP - first_special_ff;
                     state_in     = ST_DIV;
                  end
                  OP_FIXED_ADVANCE_PC: begin
                     acc_in    = cur_address_ff;
                     mcand_in  = {48'd0, item_ff.operand[15:0]};
                     mplier_in = 8'd1;
                     state_in  = ST_MUL;
                  end
                  OP_SET_PROLOGUE_END: cur_prologue_end_in = 1'b1;
                  OP_SET_EPILOGUE_BEG: cur_epilogue_begin_in = 1'b1;
                  OP_SET_ISA:          cur_isa_in = item_ff.operand[7:0];
                  default: begin
                  end
               endcase
            end else begin
               div_start = 1'b1;
               emit_in   = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               acc_in    = cur_address_ff;
               mcand_in  = {56'd0, div_res.quotient};
               mplier_in = mil_ff;
               if (emit_ff) begin
                  cur_line_in = cur_line_ff + special_step;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[7:1]};
            if (mplier_ff[7:1] == 7'd0) begin
               cur_address_in = acc_sum;
               state_in       = emit_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (fire_emit) begin
               rsp_valid_in                      = 1'b1;
               rsp_payload_in.row_address        = cur_address_ff;
               rsp_payload_in.row_line           = cur_line_ff;
               rsp_payload_in.row_file           = cur_file_ff;
               rsp_payload_in.row_column         = cur_column_ff;
               rsp_payload_in.row_isa            = cur_isa_ff;
               rsp_payload_in.row_is_stmt        = cur_is_stmt_ff;
               rsp_payload_in.row_basic_block    = cur_basic_block_ff;
               rsp_payload_in.row_end_sequence   = endseq_ff;
               rsp_payload_in.row_prologue_end   = cur_prologue_end_ff;
               rsp_payload_in.row_epilogue_begin = cur_epilogue_begin_ff;
               rsp_payload_in.lowest_address     = new_min;
               rsp_payload_in.highest_address    = new_max;
               min_seen_in           = new_min;
               max_seen_in           = new_max;
               cur_basic_block_in    = 1'b0;
               cur_prologue_end_in   = 1'b0;
               cur_epilogue_begin_in = 1'b0;
               if (endseq_ff) begin
                  cur_address_in = 64'd0;
                  cur_line_in    = 32'd1;
                  cur_file_in    = 16'd1;
                  cur_column_in  = 16'd0;
                  cur_isa_in     = 8'd0;
                  cur_is_stmt_in = dflt_stmt_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         emit_ff               <= 1'b0;
         endseq_ff             <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         mil_ff                <= 8'd1;
         dflt_stmt_ff          <= 1'b1;
         line_floor_ff         <= 8'hFB;
         line_span_ff          <= 8'd14;
         first_special_ff      <= 8'd13;
         cur_address_ff        <= 64'd0;
         cur_line_ff           <= 32'd1;
         cur_file_ff           <= 16'd1;
         cur_column_ff         <= 16'd0;
         cur_isa_ff            <= 8'd0;
         cur_is_stmt_ff        <= 1'b1;
         cur_basic_block_ff    <= 1'b0;
         cur_prologue_end_ff   <= 1'b0;
         cur_epilogue_begin_ff <= 1'b0;
         min_seen_ff           <= '1;
         max_seen_ff           <= 64'd0;
      end else begin
         state_ff              <= state_in;
         emit_ff               <= emit_in;
         endseq_ff             <= endseq_in;
         rsp_valid_ff          <= rsp_valid_in;
         mil_ff                <= mil_in;
         dflt_stmt_ff          <= dflt_stmt_in;
         line_floor_ff         <= line_floor_in;
         line_span_ff          <= line_span_in;
         first_special_ff      <= first_special_in;
         cur_address_ff        <= cur_address_in;
         cur_line_ff           <= cur_line_in;
         cur_file_ff           <= cur_file_in;
         cur_column_ff         <= cur_column_in;
         cur_isa_ff            <= cur_isa_in;
         cur_is_stmt_ff        <= cur_is_stmt_in;
         cur_basic_block_ff    <= cur_basic_block_in;
         cur_prologue_end_ff   <= cur_prologue_end_in;
         cur_epilogue_begin_ff <= cur_epilogue_begin_in;
         min_seen_ff           <= min_seen_in;
         max_seen_ff           <= max_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      acc_ff         <= acc_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `DLPI_ASSERT(a_accept_to_exec, clock, reset, req_fire |=> (state_ff == ST_EXEC), "accepted beat did not start execution")
   `DLPI_ASSERT(a_marks_bracket_row, clock, reset, rsp_if.valid |-> (rsp_payload_ff.lowest_address <= rsp_payload_ff.row_address && rsp_payload_ff.row_address <= rsp_payload_ff.highest_address), "row address lies outside the running marks")
   `DLPI_ASSERT(a_endseq_resets_row, clock, reset, (fire_emit && endseq_ff) |=> (cur_address_ff == 64'd0 && cur_line_ff == 32'd1 && cur_file_ff == 16'd1), "row state not reset after end of sequence")
   `DLPI_ASSERT(a_div_done_in_div, clock, reset, div_res.done |-> (state_ff == ST_DIV), "divider finished outside the divide step")
   `DLPI_ASSERT_NR(a_reset_clears_rsp, clock, reset |=> !rsp_if.valid, "row beat valid right after reset")

endmodule

FILE: src/dlpi_div.sv
// Bit-serial restoring divider, 8-bit dividend by 8-bit divisor, one bit a cycle.
// Depends on dlpi_pkg for the result type.
module dlpi_div import dlpi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [7:0]          dividend,
   input  logic [7:0]          divisor,
   output dlpi_div_result_type result
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] quo_ff, quo_in;
   logic       zero_ff, zero_in;
   logic [8:0] trial;
   logic [8:0] diff;
   logic       fits;

   assign trial = {rem_ff, quo_ff[7]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         rem_in  = 8'd0;
         quo_in  = dividend;
         zero_in = (divisor == 8'd0);
      end else if (busy_ff) begin
         rem_in = fits ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[6:0], fits};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = zero_ff ? 8'd0 : quo_ff;
   assign result.remainder = rem_ff;

endmodule
